>>> rtl/msm_pkg.sv
// Package for the motion safety monitor: request and result structs,
// register map, the latched fault mask and the sequencer state type.
// No dependencies.
`default_nettype none

package msm_pkg;

    localparam int DIST_W   = 16;
    localparam int AGE_W    = 32;
    localparam int TICK_W   = 16;
    localparam int SCALE_W  = 16;
    localparam int FAULT_W  = 7;
    localparam int WHEEL_W  = 4;
    localparam int QUO_W    = 15;
    localparam int BIT_W    = $clog2(AGE_W);
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // wheels checked against wheel_ok_mask; only the bits the field carries count
    localparam int NUM_WHEELS = 4;

    localparam logic [SCALE_W-1:0] FULL_SCALE = 16'h8000;
    localparam logic [FAULT_W-1:0] LATCH_BITS = 7'h48;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_STOP_DIST  = 3'd0;
    localparam logic [2:0] REG_CLEAR_HYST = 3'd1;
    localparam logic [2:0] REG_SLOW_DIST  = 3'd2;
    localparam logic [2:0] REG_MIN_SCALE  = 3'd3;
    localparam logic [2:0] REG_CMD_TMO    = 3'd4;
    localparam logic [2:0] REG_BUS_TMO    = 3'd5;
    localparam logic [2:0] REG_MIN_STOP   = 3'd6;

    localparam logic [DIST_W-1:0]  RST_STOP_DIST  = 16'd300;
    localparam logic [DIST_W-1:0]  RST_CLEAR_HYST = 16'd100;
    localparam logic [DIST_W-1:0]  RST_SLOW_DIST  = 16'd1000;
    localparam logic [SCALE_W-1:0] RST_MIN_SCALE  = 16'd0;
    localparam logic [AGE_W-1:0]   RST_CMD_TMO    = 32'd500000;
    localparam logic [AGE_W-1:0]   RST_BUS_TMO    = 32'd200000;
    localparam logic [AGE_W-1:0]   RST_MIN_STOP   = 32'd1000000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_us;
        logic [DIST_W-1:0]  obstacle_mm;
        logic               bus_good;
        logic               estop_pressed;
        logic [WHEEL_W-1:0] wheel_ok_mask;
        logic               slip_seen;
        logic               pose_lost;
        logic               command_seen;
    } t_in_item;

    typedef struct packed {
        logic [SCALE_W-1:0] speed_scale;
        logic [FAULT_W-1:0] fault_mask;
        logic               stop_needed;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/motion_safety_monitor.sv
// Motion safety monitor top level: bit-serial watchdog timers, obstacle
// threshold logic, serial restoring divider for the speed scale, APB registers.
// Depends on msm_pkg.
//
// Sequencing: an idle state, a 32-bit serial pass over the timers (one bit
// per cycle) and a commit state; the 15-bit quotient is formed inside the
// same pass. A new request is accepted only in the idle state, so the block
// takes no new request before it has committed the last. A result waiting at
// the output does not block the next request, only its commit.
// Reset (i_rst_n low, synchronous): timers, flags and latched faults clear,
// registers return to their defaults, no result is pending.
`default_nettype none

module motion_safety_monitor (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  msm_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output msm_pkg::t_out_item         o_out_data,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire  [msm_pkg::ADDR_W-1:0] paddr,
    input  wire  [msm_pkg::DATA_W-1:0] pwdata,
    output logic [msm_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import msm_pkg::*;

    localparam logic [BIT_W-1:0] LAST_BIT  = BIT_W'(AGE_W - 1);
    localparam logic [BIT_W-1:0] DIV_START = BIT_W'(DIST_W);

    // configuration
    logic [DIST_W-1:0]  r_stop_dist, r_clear_hyst, r_slow_dist;
    logic [SCALE_W-1:0] r_min_scale;
    logic [AGE_W-1:0]   r_cmd_tmo, r_bus_tmo, r_min_stop;

    // sequencer
    t_state           r_state, n_state;
    logic [BIT_W-1:0] r_bit;
    t_in_item         r_in;

    // persistent state
    logic [AGE_W-1:0]   r_cmd_age, r_bus_age, r_dwell;
    logic               r_prot, r_stop;
    logic [FAULT_W-1:0] r_latched;

    // serial pass working set
    logic [AGE_W-1:0]  r_dsum;
    logic              r_cmd_c, r_bus_c, r_dw_c, r_thr_c;
    logic              r_cmd_gt, r_cmd_ones, r_bus_gt, r_bus_ones, r_dw_ge;
    logic              r_le, r_ge_slow, r_nb, r_sb;
    logic [DIST_W-1:0] r_num, r_span, r_rem;
    logic [QUO_W-1:0]  r_quo;

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    // control
    logic accept, run_en, commit;

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_RUN;
            S_RUN:   if (r_bit == LAST_BIT) n_state = S_FINAL;
            S_FINAL: if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        run_en     = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_RUN:   run_en     = 1'b1;
            S_FINAL: commit     = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------
    // Bit-serial datapath, LSB first
    // ---------------------------------------------------------------
    logic                lo_half;
    logic [3:0]          lo_idx;
    logic                tick_b;
    logic                cmd_a, cmd_s, cmd_co, cmd_l;
    logic                bus_a, bus_b, bus_s, bus_co, bus_l;
    logic                dw_a, dw_s, dw_co, dw_m;
    logic                ob_d, ob_s, ob_h, ob_sl, thr_t, thr_co;
    logic                num_b, num_bo, span_b, span_bo;
    logic                div_act;
    logic [DIST_W-1:0]   rem_cur;
    logic [DIST_W:0]     rem_sh, rem_sub;
    logic                rem_ge;

    always_comb begin
        lo_half = ~r_bit[BIT_W-1];
        lo_idx  = r_bit[3:0];
        tick_b  = lo_half & r_in.tick_us[lo_idx];

        // command age: cleared before the add when a command arrived
        cmd_a  = ~r_in.command_seen & r_cmd_age[0];
        cmd_s  = cmd_a ^ tick_b ^ r_cmd_c;
        cmd_co = (cmd_a & tick_b) | (r_cmd_c & (cmd_a ^ tick_b));
        cmd_l  = r_cmd_tmo[r_bit];

        // bus age: forced to zero on a good tick
        bus_a  = ~r_in.bus_good & r_bus_age[0];
        bus_b  = ~r_in.bus_good & tick_b;
        bus_s  = bus_a ^ bus_b ^ r_bus_c;
        bus_co = (bus_a & bus_b) | (r_bus_c & (bus_a ^ bus_b));
        bus_l  = r_bus_tmo[r_bit];

        // dwell candidate
        dw_a  = r_dwell[r_bit];
        dw_s  = dw_a ^ tick_b ^ r_dw_c;
        dw_co = (dw_a & tick_b) | (r_dw_c & (dw_a ^ tick_b));
        dw_m  = r_min_stop[r_bit];

        // obstacle threshold, num and span over the low half
        ob_d   = r_in.obstacle_mm[lo_idx];
        ob_s   = r_stop_dist[lo_idx];
        ob_h   = r_prot & r_clear_hyst[lo_idx];
        ob_sl  = r_slow_dist[lo_idx];
        thr_t  = ob_s ^ ob_h ^ r_thr_c;
        thr_co = (ob_s & ob_h) | (r_thr_c & (ob_s ^ ob_h));
        num_b  = ob_d ^ ob_s ^ r_nb;
        num_bo = (~ob_d & ob_s) | (~(ob_d ^ ob_s) & r_nb);
        span_b = ob_sl ^ ob_s ^ r_sb;
        span_bo = (~ob_sl & ob_s) | (~(ob_sl ^ ob_s) & r_sb);

        // restoring divider step over the high half
        div_act = r_bit[BIT_W-1] && (r_bit != LAST_BIT);
        rem_cur = (r_bit == DIV_START) ? r_num : r_rem;
        rem_sh  = {rem_cur, 1'b0};
        rem_ge  = rem_sh >= {1'b0, r_span};
        rem_sub = rem_sh - {1'b0, r_span};
    end

    // ---------------------------------------------------------------
    // Commit values
    // ---------------------------------------------------------------
    logic               cmd_to, bus_to, obst, wheel_flt, dw_ge;
    logic [WHEEL_W-1:0] need;
    logic [FAULT_W-1:0] faults, lat_nx;
    logic [AGE_W-1:0]   dsum_sat;
    logic [SCALE_W-1:0] min_sat, scale_zone;
    logic               stop_nx;
    logic [AGE_W-1:0]   dwell_nx;

    always_comb begin
        for (int i = 0; i < WHEEL_W; i++) begin
            need[i] = (i < NUM_WHEELS);
        end
        cmd_to    = r_cmd_c ? ~r_cmd_ones : r_cmd_gt;
        bus_to    = r_bus_c ? ~r_bus_ones : r_bus_gt;
        obst      = r_thr_c | r_le;
        wheel_flt = |(~r_in.wheel_ok_mask & need);
        faults    = {r_in.estop_pressed, r_in.pose_lost, r_in.slip_seen,
                     wheel_flt, bus_to, cmd_to, obst};
        lat_nx    = (r_latched & LATCH_BITS) | faults;
        dsum_sat  = r_dw_c ? {AGE_W{1'b1}} : r_dsum;
        dw_ge     = r_dw_c | r_dw_ge;
        min_sat   = (r_min_scale > FULL_SCALE) ? FULL_SCALE : r_min_scale;

        priority if (obst) begin
            scale_zone = min_sat;
        end else if (r_ge_slow) begin
            scale_zone = FULL_SCALE;
        end else begin
            scale_zone = {1'b0, r_quo};
        end

        stop_nx  = r_stop;
        dwell_nx = r_dwell;
        priority if (lat_nx != '0) begin
            stop_nx  = 1'b1;
            dwell_nx = '0;
        end else if (r_stop) begin
            if (dw_ge) begin
                stop_nx  = 1'b0;
                dwell_nx = '0;
            end else begin
                dwell_nx = dsum_sat;
            end
        end else begin
            // no stop and no fault: hold the dwell timer
            dwell_nx = r_dwell;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_cmd_age   <= '0;
            r_bus_age   <= '0;
            r_dwell     <= '0;
            r_prot      <= 1'b0;
            r_stop      <= 1'b0;
            r_latched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_bit <= '0;
            end else if (run_en) begin
                r_bit <= r_bit + 1'b1;
                // rotate the ages in place; the sum enters at the top
                r_cmd_age <= {cmd_s, r_cmd_age[AGE_W-1:1]};
                r_bus_age <= {bus_s, r_bus_age[AGE_W-1:1]};
            end else if (commit) begin
                if (r_cmd_c) r_cmd_age <= '1;
                if (r_bus_c) r_bus_age <= '1;
                r_dwell   <= dwell_nx;
                r_stop    <= stop_nx;
                r_prot    <= obst;
                r_latched <= lat_nx;
            end

            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in       <= i_in_data;
            r_cmd_c    <= 1'b0;
            r_bus_c    <= 1'b0;
            r_dw_c     <= 1'b0;
            r_thr_c    <= 1'b0;
            r_cmd_gt   <= 1'b0;
            r_bus_gt   <= 1'b0;
            r_cmd_ones <= 1'b1;
            r_bus_ones <= 1'b1;
            r_dw_ge    <= 1'b1;
            r_le       <= 1'b1;
            r_ge_slow  <= 1'b1;
            r_nb       <= 1'b0;
            r_sb       <= 1'b0;
        end else if (run_en) begin
            r_cmd_c    <= cmd_co;
            r_bus_c    <= bus_co;
            r_dw_c     <= dw_co;
            if (cmd_s != cmd_l) r_cmd_gt <= cmd_s;
            if (bus_s != bus_l) r_bus_gt <= bus_s;
            if (dw_s != dw_m)   r_dw_ge  <= dw_s;
            r_cmd_ones <= r_cmd_ones & cmd_l;
            r_bus_ones <= r_bus_ones & bus_l;
            r_dsum     <= {dw_s, r_dsum[AGE_W-1:1]};
            if (lo_half) begin
                r_thr_c <= thr_co;
                if (ob_d != thr_t) r_le      <= ~ob_d;
                if (ob_d != ob_sl) r_ge_slow <= ob_d;
                r_nb   <= num_bo;
                r_sb   <= span_bo;
                r_num  <= {num_b, r_num[DIST_W-1:1]};
                r_span <= {span_b, r_span[DIST_W-1:1]};
            end
            if (div_act) begin
                r_rem <= rem_ge ? rem_sub[DIST_W-1:0] : rem_sh[DIST_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            end
        end

        if (commit) begin
            r_out.speed_scale <= stop_nx ? '0 : scale_zone;
            r_out.fault_mask  <= lat_nx;
            r_out.stop_needed <= stop_nx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------
    // APB register port
    // ---------------------------------------------------------------
    logic       cfg_we;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_dist  <= RST_STOP_DIST;
            r_clear_hyst <= RST_CLEAR_HYST;
            r_slow_dist  <= RST_SLOW_DIST;
            r_min_scale  <= RST_MIN_SCALE;
            r_cmd_tmo    <= RST_CMD_TMO;
            r_bus_tmo    <= RST_BUS_TMO;
            r_min_stop   <= RST_MIN_STOP;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_STOP_DIST:  r_stop_dist  <= pwdata[DIST_W-1:0];
                REG_CLEAR_HYST: r_clear_hyst <= pwdata[DIST_W-1:0];
                REG_SLOW_DIST:  r_slow_dist  <= pwdata[DIST_W-1:0];
                REG_MIN_SCALE:  r_min_scale  <= pwdata[SCALE_W-1:0];
                REG_CMD_TMO:    r_cmd_tmo    <= pwdata[AGE_W-1:0];
                REG_BUS_TMO:    r_bus_tmo    <= pwdata[AGE_W-1:0];
                REG_MIN_STOP:   r_min_stop   <= pwdata[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_STOP_DIST:  prdata = DATA_W'(r_stop_dist);
            REG_CLEAR_HYST: prdata = DATA_W'(r_clear_hyst);
            REG_SLOW_DIST:  prdata = DATA_W'(r_slow_dist);
            REG_MIN_SCALE:  prdata = DATA_W'(r_min_scale);
            REG_CMD_TMO:    prdata = r_cmd_tmo;
            REG_BUS_TMO:    prdata = r_bus_tmo;
            REG_MIN_STOP:   prdata = r_min_stop;
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire
